/* design/pmpn_pkg.sv */
// shared constants, register codes and nibble packing for the planar to packed converter
`timescale 1ns / 1ps

package pmpn_pkg;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 1024;

  localparam int IMAGE_WIDTH_W  = 12;
  localparam int IMAGE_HEIGHT_W = 11;
  localparam int CFG_DATA_W     = 12;
  localparam int INDEX_W        = 10;
  localparam int BYTE_W         = 8;
  localparam int STORE_W        = 3 * BYTE_W;

  localparam logic [IMAGE_WIDTH_W-1:0]  IMAGE_WIDTH_RST  = 12'd8;
  localparam logic [IMAGE_HEIGHT_W-1:0] IMAGE_HEIGHT_RST = 11'd1;

  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [2:0] PLANE_MASK = 3'd0;
  localparam logic [2:0] PLANE_1    = 3'd1;
  localparam logic [2:0] PLANE_2    = 3'd2;
  localparam logic [2:0] PLANE_3    = 3'd3;
  localparam logic [2:0] PLANE_4    = 3'd4;

  localparam logic [1:0] LAST_SLOT = 2'd3;

  // planes is {p4, p3, p2, p1}; slot k packs pixels 2k and 2k+1
  function automatic logic [BYTE_W-1:0] pack_pair(input logic [4*BYTE_W-1:0] planes,
                                                  input logic [1:0] k);
    logic [2:0] sh;
    logic [2:0] sl;
    logic [BYTE_W-1:0] p1;
    logic [BYTE_W-1:0] p2;
    logic [BYTE_W-1:0] p3;
    logic [BYTE_W-1:0] p4;
    p1 = planes[BYTE_W-1:0];
    p2 = planes[2*BYTE_W-1:BYTE_W];
    p3 = planes[3*BYTE_W-1:2*BYTE_W];
    p4 = planes[4*BYTE_W-1:3*BYTE_W];
    sh = {~k, 1'b1};
    sl = {~k, 1'b0};
    return {p3[sh], p4[sh], p2[sh], p1[sh], p3[sl], p4[sl], p2[sl], p1[sl]};
  endfunction

endpackage

/* design/planar_mask_to_packed_nibble_core.sv */
// planar 1bpp to packed 4bpp converter with mask pass-through
//
// input channel: one source byte per item (in_valid / in_stall), in memory
// order: per row a mask plane, then color planes 1 to 4, each
// ceil(image_width/8) bytes. output channel: one result item per unstalled
// cycle (out_valid / out_stall) with target, row, byte offset, data and flags.
// a mask byte gives one result, a plane 1 to 3 byte gives none and is kept
// in a 24-bit wide row store (one entry per column, read-modify-write with
// a registered bypass), a plane 4 byte gives four packed color bytes.
// throughput: mask and plane 1 to 3 bytes, one item per cycle while in_stall
// is low; a plane 4 byte occupies the output register for four results,
// so the input holds off while the next producing item waits behind it.
// an accepted item passes the store read stage, then the output register.
// reset clears the plane, column and row counters and the pipeline and
// loads image_width 8, image_height 1; the row store is not cleared.
// while the receiver stalls, the output holds its result and the input
// stalls as soon as a second producing item is waiting.
`timescale 1ns / 1ps

module planar_mask_to_packed_nibble_core import pmpn_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [BYTE_W-1:0]     source_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  target,
  output logic [INDEX_W-1:0]    row_index,
  output logic [INDEX_W-1:0]    byte_index,
  output logic [BYTE_W-1:0]     out_byte,
  output logic                  run_end,
  output logic                  frame_end
);

  localparam int ROW_BYTES = MAX_WIDTH / 8;
  localparam int COL_SPAN  = (MAX_WIDTH + 7) / 8;
  localparam int AW  = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
  localparam int CCW = (COL_SPAN > 1) ? $clog2(COL_SPAN) : 1;
  localparam int SW  = $clog2(COL_SPAN + 1);
  localparam int WW  = ($clog2(MAX_WIDTH + 1) > IMAGE_WIDTH_W) ?
                       $clog2(MAX_WIDTH + 1) : IMAGE_WIDTH_W;
  localparam int HW  = ($clog2(MAX_HEIGHT + 1) > IMAGE_HEIGHT_W) ?
                       $clog2(MAX_HEIGHT + 1) : IMAGE_HEIGHT_W;
  localparam int RCW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  logic [IMAGE_WIDTH_W-1:0]  image_width;
  logic [IMAGE_HEIGHT_W-1:0] image_height;

  logic [2:0]     plane_number;
  logic [2:0]     plane_number_next;
  logic [CCW-1:0] column_count;
  logic [CCW-1:0] column_count_next;
  logic [RCW-1:0] row_count;
  logic [RCW-1:0] row_count_next;

  logic [WW-1:0] width_eff;
  logic [WW:0]   width_round;
  logic [SW-1:0] stride;
  logic [HW-1:0] height_eff;
  logic          col_last;
  logic          row_last;
  logic          accept;
  logic [AW-1:0] col_addr;
  logic [INDEX_W-1:0] color_row;

  logic               s1_valid;
  logic [2:0]         s1_plane;
  logic [AW-1:0]      s1_col;
  logic [INDEX_W-1:0] s1_row;
  logic [BYTE_W-1:0]  s1_byte;
  logic               s1_frame;
  logic               s1_prod;
  logic               s1_hold;

  logic               ram_we;
  logic [AW-1:0]      ram_raddr;
  logic [STORE_W-1:0] ram_wdata;
  logic [STORE_W-1:0] ram_rdata;
  logic               fwd;
  logic [STORE_W-1:0] fwd_data;
  logic [STORE_W-1:0] cur;

  logic                e_valid;
  logic                e_target;
  logic [INDEX_W-1:0]  e_row;
  logic [AW-1:0]       e_col;
  logic [1:0]          e_k;
  logic [4*BYTE_W-1:0] e_planes;
  logic                e_frame;
  logic                e_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMAGE_WIDTH_RST;
      image_height <= IMAGE_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[IMAGE_WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[IMAGE_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped geometry
  always_comb begin
    width_eff = WW'(image_width);
    if (width_eff == '0) begin
      width_eff = WW'(1);
    end else if (width_eff > WW'(MAX_WIDTH)) begin
      width_eff = WW'(MAX_WIDTH);
    end
    width_round = {1'b0, width_eff} + (WW + 1)'(7);
    stride      = SW'(width_round >> 3);
    height_eff = HW'(image_height);
    if (height_eff == '0) begin
      height_eff = HW'(1);
    end else if (height_eff > HW'(MAX_HEIGHT)) begin
      height_eff = HW'(MAX_HEIGHT);
    end
  end

  assign col_last  = SW'(column_count) >= (stride - SW'(1));
  assign row_last  = HW'(row_count) >= (height_eff - HW'(1));
  assign color_row = INDEX_W'(height_eff - HW'(1) - HW'(row_count));
  assign col_addr  = (column_count >= CCW'(ROW_BYTES - 1)) ? AW'(ROW_BYTES - 1) :
                     AW'(column_count);

  assign s1_prod  = s1_valid && (s1_plane == PLANE_MASK || s1_plane == PLANE_4);
  assign e_free   = !e_valid || (!out_stall && e_k == LAST_SLOT);
  assign s1_hold  = s1_prod && !e_free;
  assign in_stall = s1_hold;
  assign accept   = in_valid && !in_stall;

  // position counters
  always_comb begin
    plane_number_next = plane_number;
    column_count_next = column_count;
    row_count_next    = row_count;
    if (accept) begin
      if (!col_last) begin
        column_count_next = column_count + CCW'(1);
      end else begin
        column_count_next = '0;
        if (plane_number < PLANE_4) begin
          plane_number_next = plane_number + 3'd1;
        end else begin
          plane_number_next = PLANE_MASK;
          row_count_next    = row_last ? '0 : row_count + RCW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_number <= PLANE_MASK;
      column_count <= '0;
      row_count    <= '0;
    end else begin
      plane_number <= plane_number_next;
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // store read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (!s1_hold) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_plane <= plane_number;
      s1_col   <= col_addr;
      s1_row   <= (plane_number == PLANE_4) ? color_row : INDEX_W'(row_count);
      s1_byte  <= source_byte;
      s1_frame <= (plane_number == PLANE_4) && col_last && row_last;
    end
  end

  assign ram_raddr = s1_hold ? s1_col : col_addr;
  assign ram_we    = s1_valid && (s1_plane == PLANE_1 || s1_plane == PLANE_2 ||
                                  s1_plane == PLANE_3);
  assign cur       = fwd ? fwd_data : ram_rdata;

  always_comb begin
    case (s1_plane)
      PLANE_1: ram_wdata = {cur[STORE_W-1:BYTE_W], s1_byte};
      PLANE_2: ram_wdata = {cur[STORE_W-1:2*BYTE_W], s1_byte, cur[BYTE_W-1:0]};
      PLANE_3: ram_wdata = {s1_byte, cur[2*BYTE_W-1:0]};
      default: ram_wdata = cur;
    endcase
  end

  // bypass for a read issued at the edge the same column is written
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else begin
      fwd <= ram_we && (s1_col == ram_raddr);
    end
  end

  always_ff @(posedge clk) begin
    fwd_data <= ram_wdata;
  end

  pmpn_ram #(
    .WIDTH(STORE_W),
    .DEPTH(ROW_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_col),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // output register; color items step through four slots, mask items use one
  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (e_free) begin
      e_valid <= s1_prod;
    end
  end

  always_ff @(posedge clk) begin
    if (e_free && s1_prod) begin
      e_target <= (s1_plane == PLANE_4);
      e_row    <= s1_row;
      e_col    <= s1_col;
      e_k      <= (s1_plane == PLANE_4) ? 2'd0 : LAST_SLOT;
      e_planes <= (s1_plane == PLANE_4) ? {s1_byte, cur} :
                  {{(3 * BYTE_W){1'b0}}, s1_byte};
      e_frame  <= s1_frame;
    end else if (e_valid && !out_stall && e_k != LAST_SLOT) begin
      e_k <= e_k + 2'd1;
    end
  end

  assign out_valid  = e_valid;
  assign target     = e_target;
  assign row_index  = e_row;
  assign byte_index = e_target ? INDEX_W'({e_col, e_k}) : INDEX_W'(e_col);
  assign out_byte   = e_target ? pack_pair(e_planes, e_k) : e_planes[BYTE_W-1:0];
  assign run_end    = (e_k == LAST_SLOT);
  assign frame_end  = e_frame && (e_k == LAST_SLOT);

`ifndef SYNTHESIS
  a_frame_end_last_color: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> run_end && target)
    else $error("frame end outside a final color result");

  a_mask_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && !target |-> run_end && !frame_end)
    else $error("mask result not a single-result run");

  a_color_sequence: assert property (@(posedge clk) disable iff (rst)
    out_valid && target && !run_end && !out_stall |=>
      out_valid && target && byte_index == $past(byte_index) + 10'd1)
    else $error("color run broken before its last byte");

  a_stall_only_when_busy: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && s1_valid)
    else $error("input stalled with the output register free");
`endif

endmodule

/* design/pmpn_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps

module pmpn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
